// File: sv/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and codes for the layered profile interpolator.
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int DEPTH_W  = 24;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int PROD_W   = VALUE_W + DEPTH_W;
    localparam int ENTRY_W  = DEPTH_W + 2 * VALUE_W;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [VALUE_W-1:0] upper;
        logic [VALUE_W-1:0] lower;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_Q_FIRST,
        S_Q_SCAN,
        S_Q_MUL,
        S_Q_DST,
        S_Q_DIV,
        S_OUT
    } t_state;

endpackage

// File: sv/lpi_if.sv
// ----------------------------------------------------------------------------
// lpi_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface lpi_in_if
    import lpi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [DEPTH_W-1:0]        boundary_depth;
    logic signed [VALUE_W-1:0] upper_value;
    logic signed [VALUE_W-1:0] lower_value;
    logic [INDEX_W-1:0]        sample_index;

    modport source (
        output valid, kind, boundary_depth, upper_value, lower_value, sample_index,
        input  ready
    );
    modport sink (
        input  valid, kind, boundary_depth, upper_value, lower_value, sample_index,
        output ready
    );
endinterface

interface lpi_out_if
    import lpi_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sample_value;
    logic [1:0]                status;

    modport source (
        output valid, sample_value, status,
        input  ready
    );
    modport sink (
        input  valid, sample_value, status,
        output ready
    );
endinterface

// File: sv/lpi_ram.sv
// ----------------------------------------------------------------------------
// lpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lpi_div.sv
// ----------------------------------------------------------------------------
// lpi_div
// Restoring divider, one quotient bit per cycle, for a product over a span.
// ----------------------------------------------------------------------------
module lpi_div
    import lpi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PROD_W-1:0]  i_dividend,
    input  logic [DEPTH_W-1:0] i_divisor,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEPTH_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [DEPTH_W-1:0] r_div;

    logic [DEPTH_W:0]   w_trial;
    logic               w_ge;
    logic [DEPTH_W:0]   w_diff;
    logic [DEPTH_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_W-1]};
        w_ge    = (w_trial >= {1'b0, r_div});
        w_diff  = w_trial - {1'b0, r_div};
        n_rem   = w_ge ? w_diff[DEPTH_W-1:0] : w_trial[DEPTH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[PROD_W-1:VALUE_W];
            r_quo <= i_dividend[VALUE_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[VALUE_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: sv/layered_profile_interpolator.sv
// ----------------------------------------------------------------------------
// layered_profile_interpolator
// Sorted boundary table with piecewise-linear lookup of sample values.
// ----------------------------------------------------------------------------
//  port    dir  beat carries
//  i_in    in   kind, boundary_depth, upper_value, lower_value, sample_index
//  o_out   out  sample_value, status
//
//  clear, dropped insert, unused kind, empty query, insert into an empty
//  table: result beat in the next cycle
//  insert: entries deeper than the new one move down a slot, one per cycle
//  (one RAM port), then the new entry is written; query: table scan, then
//  the multiply and the bit-serial divider
//  reset clears the state and the entry count; the table RAM is not swept
//  i_in.ready is low from a request beat until its result beat is taken
// ----------------------------------------------------------------------------
module layered_profile_interpolator
    import lpi_pkg::*;
#(
    parameter int MAX_BOUNDARIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpi_in_if.sink      i_in,
    lpi_out_if.source   o_out
);

    localparam int IW = (MAX_BOUNDARIES > 1) ? $clog2(MAX_BOUNDARIES) : 1;
    localparam int CW = $clog2(MAX_BOUNDARIES + 1);

    t_state             r_state,  n_state;
    logic [CW-1:0]      r_count,  n_count;
    logic [IW-1:0]      r_idx,    n_idx;
    t_entry             r_new,    n_new;
    logic [DEPTH_W-1:0] r_z,      n_z;
    logic [DEPTH_W-1:0] r_pdepth, n_pdepth;
    logic [VALUE_W-1:0] r_plower, n_plower;
    logic [VALUE_W-1:0] r_mag,    n_mag;
    logic [DEPTH_W-1:0] r_dist,   n_dist;
    logic [DEPTH_W-1:0] r_span,   n_span;
    logic               r_neg,    n_neg;
    logic [VALUE_W-1:0] r_vb,     n_vb;
    logic [PROD_W-1:0]  r_prod,   n_prod;
    logic [VALUE_W-1:0] r_value,  n_value;
    logic [1:0]         r_status, n_status;

    logic               w_we;
    logic [IW-1:0]      w_waddr;
    t_entry             w_wdata;
    logic [IW-1:0]      w_raddr;
    t_entry             w_rd;
    logic               w_div_done;
    logic [VALUE_W-1:0] w_quo;
    logic [DEPTH_W-1:0] w_span;
    logic               w_up_ge;
    logic [VALUE_W+1:0] w_sum;
    logic               w_accept;

    lpi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BOUNDARIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    lpi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_Q_DST),
        .i_dividend (r_prod),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_accept = i_in.valid && i_in.ready;
    assign w_span   = w_rd.depth - r_pdepth;
    assign w_up_ge  = ($signed(w_rd.upper) >= $signed(r_plower));
    assign w_sum    = {{2{r_vb[VALUE_W-1]}}, r_vb}
                    + (r_neg ? ((VALUE_W+2)'(0) - {2'b00, w_quo}) : {2'b00, w_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_new    <= n_new;
        r_z      <= n_z;
        r_pdepth <= n_pdepth;
        r_plower <= n_plower;
        r_mag    <= n_mag;
        r_dist   <= n_dist;
        r_span   <= n_span;
        r_neg    <= n_neg;
        r_vb     <= n_vb;
        r_prod   <= n_prod;
        r_value  <= n_value;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_new    = r_new;
        n_z      = r_z;
        n_pdepth = r_pdepth;
        n_plower = r_plower;
        n_mag    = r_mag;
        n_dist   = r_dist;
        n_span   = r_span;
        n_neg    = r_neg;
        n_vb     = r_vb;
        n_prod   = r_prod;
        n_value  = r_value;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_idx;
        w_wdata  = r_new;
        w_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_value  = '0;
                    n_status = STATUS_OK;
                    n_state  = S_OUT;
                    unique case (i_in.kind)
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        KIND_INSERT: begin
                            n_new.depth = i_in.boundary_depth;
                            n_new.upper = i_in.upper_value;
                            n_new.lower = i_in.lower_value;
                            if (r_count >= CW'(MAX_BOUNDARIES)) begin
                                n_status = STATUS_FULL;
                            end else if (r_count == '0) begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = n_new;
                                n_count = r_count + CW'(1);
                            end else begin
                                n_idx   = IW'(r_count);
                                w_raddr = IW'(r_count - CW'(1));
                                n_state = S_INS_CMP;
                            end
                        end
                        KIND_QUERY: begin
                            if (r_count == '0) begin
                                n_status = STATUS_EMPTY;
                            end else begin
                                n_z     = {i_in.sample_index, FRAC_W'(0)};
                                w_raddr = '0;
                                n_state = S_Q_FIRST;
                            end
                        end
                        default: begin
                            n_status = STATUS_OK;
                        end
                    endcase
                end
            end

            // walk down from the tail, moving deeper entries one slot on
            S_INS_CMP: begin
                if (w_rd.depth > r_new.depth) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx;
                    w_wdata = w_rd;
                    if (r_idx == IW'(1)) begin
                        n_idx   = '0;
                        n_state = S_INS_PUT;
                    end else begin
                        n_idx   = r_idx - IW'(1);
                        w_raddr = r_idx - IW'(2);
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx;
                    w_wdata = r_new;
                    n_count = r_count + CW'(1);
                    n_state = S_OUT;
                end
            end

            S_INS_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_new;
                n_count = r_count + CW'(1);
                n_state = S_OUT;
            end

            S_Q_FIRST: begin
                if (r_z < w_rd.depth) begin
                    n_value = w_rd.upper;
                    n_state = S_OUT;
                end else if (r_count == CW'(1)) begin
                    n_value = w_rd.lower;
                    n_state = S_OUT;
                end else begin
                    n_pdepth = w_rd.depth;
                    n_plower = w_rd.lower;
                    n_idx    = IW'(1);
                    w_raddr  = IW'(1);
                    n_state  = S_Q_SCAN;
                end
            end

            S_Q_SCAN: begin
                if (r_z > w_rd.depth) begin
                    if (CW'(r_idx) + CW'(1) == r_count) begin
                        n_value = w_rd.lower;
                        n_state = S_OUT;
                    end else begin
                        n_pdepth = w_rd.depth;
                        n_plower = w_rd.lower;
                        n_idx    = r_idx + IW'(1);
                        w_raddr  = r_idx + IW'(1);
                    end
                end else if (w_span == '0) begin
                    n_value = w_rd.upper;
                    n_state = S_OUT;
                end else begin
                    n_span  = w_span;
                    n_dist  = r_z - r_pdepth;
                    n_vb    = r_plower;
                    n_neg   = !w_up_ge;
                    n_mag   = w_up_ge ? (w_rd.upper - r_plower) : (r_plower - w_rd.upper);
                    n_state = S_Q_MUL;
                end
            end

            S_Q_MUL: begin
                n_prod  = r_mag * r_dist;
                n_state = S_Q_DST;
            end

            S_Q_DST: begin
                n_state = S_Q_DIV;
            end

            S_Q_DIV: begin
                if (w_div_done) begin
                    n_value = w_sum[VALUE_W-1:0];
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.sample_value = r_value;
    assign o_out.status       = r_status;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request and result beats open at once");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOUNDARIES))
        else $error("entry count beyond table size");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != STATUS_OK) |-> (o_out.sample_value == '0))
        else $error("flagged result carries a value");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_Q_DIV))
        else $error("divider finished outside a query");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_count != $past(r_count)) |->
            (r_count == '0 || r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by more than one insert");

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the layered profile interpolator. A short directed
// run covers an empty table, unused kind, equal depths and value extremes;
// random table builds with clustered depths, full tables and nearby queries
// follow. A scoreboard keeps its own boundary table, predicts every result
// beat and checks each field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
    import lpi_pkg::*;
();

    localparam int MAX_B        = 16;
    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 1000;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 600000;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [1:0]                status;
    } t_sample;

    class profile_scoreboard;
        logic [DEPTH_W-1:0]        depth_tab [MAX_B];
        logic signed [VALUE_W-1:0] upper_tab [MAX_B];
        logic signed [VALUE_W-1:0] lower_tab [MAX_B];
        int                        entry_cnt;
        t_sample                   expected_samples [$];
        int                        mismatches;

        function new();
            entry_cnt  = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        function void note_request(input logic [1:0] kind, input logic [DEPTH_W-1:0] depth,
                                   input logic signed [VALUE_W-1:0] upper,
                                   input logic signed [VALUE_W-1:0] lower,
                                   input logic [INDEX_W-1:0] index);
            t_sample            r;
            int                 pos;
            int                 k;
            logic [DEPTH_W-1:0] z;
            logic [DEPTH_W-1:0] span;
            longint             vb;
            longint             va;
            longint             num;
            r.value  = '0;
            r.status = STATUS_OK;
            case (kind)
                KIND_CLEAR: begin
                    entry_cnt = 0;
                end
                KIND_INSERT: begin
                    if (entry_cnt >= MAX_B) begin
                        r.status = STATUS_FULL;
                    end else begin
                        pos = 0;
                        while (pos < entry_cnt && depth_tab[pos] <= depth) pos++;
                        for (int i = entry_cnt; i > pos; i--) begin
                            depth_tab[i] = depth_tab[i-1];
                            upper_tab[i] = upper_tab[i-1];
                            lower_tab[i] = lower_tab[i-1];
                        end
                        depth_tab[pos] = depth;
                        upper_tab[pos] = upper;
                        lower_tab[pos] = lower;
                        entry_cnt++;
                    end
                end
                KIND_QUERY: begin
                    if (entry_cnt == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        z = {index, 8'h00};
                        if (z < depth_tab[0]) begin
                            r.value = upper_tab[0];
                        end else begin
                            k = 0;
                            while (k + 1 < entry_cnt && z > depth_tab[k+1]) k++;
                            if (k + 1 >= entry_cnt) begin
                                r.value = lower_tab[entry_cnt-1];
                            end else begin
                                span = depth_tab[k+1] - depth_tab[k];
                                if (span == 0) begin
                                    r.value = upper_tab[k+1];
                                end else begin
                                    vb  = lower_tab[k];
                                    va  = upper_tab[k+1];
                                    num = (va - vb) * (longint'(z) - longint'(depth_tab[k]));
                                    r.value = VALUE_W'(vb + num / longint'(span));
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            expected_samples = {expected_samples, r};
        endfunction

        task check_sample(input logic signed [VALUE_W-1:0] value,
                          input logic [1:0] status);
            t_sample e;
            if (expected_samples.size() == 0) begin
                report($sformatf("result beat with none expected: value %0d status %0d",
                                 value, status));
                return;
            end
            e = expected_samples.pop_front();
            if (value !== e.value)
                report($sformatf("sample_value %0d, expected %0d", value, e.value));
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lpi_in_if  in_bus ();
    lpi_out_if out_bus ();

    layered_profile_interpolator #(
        .MAX_BOUNDARIES (MAX_B)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    profile_scoreboard sb = new();
    int                cycle_cnt  = 0;
    int                items_sent = 0;
    int                burst_left = 0;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("layered_profile_interpolator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready)
            sb.check_sample(out_bus.sample_value, out_bus.status);
    end

    // result stalls: stretches of no stall, short stalls, long stalls
    initial begin
        int stall_left;
        int mode;
        stall_left    = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            mode = (cycle_cnt / 300) % 3;
            if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else if (mode != 0 && $urandom_range(0, 3) == 0) begin
                out_bus.ready <= 1'b0;
                stall_left = (mode == 2) ? $urandom_range(4, 20) : $urandom_range(0, 3);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return VALUE_W'($signed($urandom_range(0, 512)) - 256);
            default: return $urandom;
        endcase
    endfunction

    task automatic idle_cycle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        idle_cycle();
        while (sb.pending() != 0) idle_cycle();
    endtask

    task automatic send_beat(input logic [1:0] kind, input logic [DEPTH_W-1:0] depth,
                             input logic signed [VALUE_W-1:0] upper,
                             input logic signed [VALUE_W-1:0] lower,
                             input logic [INDEX_W-1:0] index);
        int gap;
        @(negedge i_clk);
        in_bus.valid          <= 1'b1;
        in_bus.kind           <= kind;
        in_bus.boundary_depth <= depth;
        in_bus.upper_value    <= upper;
        in_bus.lower_value    <= lower;
        in_bus.sample_index   <= index;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        sb.note_request(kind, depth, upper, lower, index);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 12);
            repeat (gap) idle_cycle();
            burst_left = $urandom_range(1, 24);
        end
    endtask

    initial begin
        int                 n_bounds;
        int                 n_queries;
        int                 base;
        int                 spread;
        int                 dv;
        int                 qi;
        bit                 clustered;
        logic [DEPTH_W-1:0] last_depth;

        in_bus.valid          = 1'b0;
        in_bus.kind           = KIND_CLEAR;
        in_bus.boundary_depth = '0;
        in_bus.upper_value    = '0;
        in_bus.lower_value    = '0;
        in_bus.sample_index   = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, unused kind, extremes, equal depths
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0);
        send_beat(KIND_UNUSED, 24'hFFFFFF, V_MAX, V_MIN, 16'hFFFF);
        send_beat(KIND_INSERT, 24'h000100, V_MAX, V_MIN, 16'h0);
        send_beat(KIND_INSERT, 24'hFFFFFF, V_MIN, V_MAX, 16'h0);
        send_beat(KIND_INSERT, 24'h000100, 32'sh12345678, -32'sd5, 16'h0);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0000);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0001);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h8000);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'hFFFF);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0002);
        send_beat(KIND_INSERT, 24'h000000, 0, V_MAX, 16'h0);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0000);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0001);
        send_beat(KIND_INSERT, 24'h000180, -32'sd1, 32'sd1, 16'h0);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0001);
        send_beat(KIND_CLEAR, 24'hFFFFFF, V_MAX, V_MAX, 16'hFFFF);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0001);
        send_beat(KIND_INSERT, 24'hFFFF00, V_MIN, V_MAX, 16'h0);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'hFFFF);
        send_beat(KIND_QUERY, 24'h0, 0, 0, 16'h0000);
        wait_drain();

        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 8) begin
                // table build then lookups around its depths
                send_beat(KIND_CLEAR, DEPTH_W'($urandom), $urandom, $urandom,
                          INDEX_W'($urandom));
                n_bounds  = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 19)
                                                        : $urandom_range(1, 8);
                clustered = $urandom_range(0, 2) != 0;
                base      = $urandom_range(0, 24'hFFFFFF);
                spread    = 1 << $urandom_range(4, 16);
                last_depth = '0;
                for (int i = 0; i < n_bounds; i++) begin
                    dv = clustered ? base + $urandom_range(0, spread) : $urandom_range(0, 24'hFFFFFF);
                    if (dv > 24'hFFFFFF) dv = 24'hFFFFFF;
                    if (i > 0 && $urandom_range(0, 5) == 0) dv = last_depth;
                    last_depth = DEPTH_W'(dv);
                    send_beat(KIND_INSERT, DEPTH_W'(dv), pick_value(), pick_value(),
                              INDEX_W'($urandom));
                end
                n_queries = $urandom_range(2, 10);
                for (int i = 0; i < n_queries; i++) begin
                    case ($urandom_range(0, 7))
                        0:       qi = 0;
                        1:       qi = 16'hFFFF;
                        2:       qi = $urandom_range(0, 16'hFFFF);
                        default: qi = (clustered ? base : last_depth) / 256 - 1
                                      + $urandom_range(0, spread / 256 + 2);
                    endcase
                    if (qi < 0) qi = 0;
                    if (qi > 16'hFFFF) qi = 16'hFFFF;
                    send_beat(KIND_QUERY, DEPTH_W'($urandom), $urandom, $urandom,
                              INDEX_W'(qi));
                end
            end else begin
                send_beat(2'($urandom_range(0, 3)), DEPTH_W'($urandom), pick_value(),
                          pick_value(), INDEX_W'($urandom));
            end
            if ($urandom_range(0, 30) == 0) wait_drain();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("layered_profile_interpolator regression: pass");
        end else begin
            $display("layered_profile_interpolator regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/lpi_pkg.sv
sv/lpi_if.sv
sv/lpi_ram.sv
sv/lpi_div.sv
sv/layered_profile_interpolator.sv
test/tb_top.sv
